@@ sv/hsv_to_rgb_converter_defines.svh @@
// Assertion macros shared by the HSV to RGB checker.
// Depends on nothing; the including scope provides clock and reset.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on clock, quiet during reset
`define HSV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset
`define HSV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/hsv_pkg.sv @@
// Shared widths, constants and the hue sector type of the HSV to RGB converter.
// No dependencies.
`default_nettype none

package hsv_pkg;

   // Field and datapath widths
   localparam int HUE_W  = 8;
   localparam int PCT_W  = 7;
   localparam int CH_W   = 8;
   localparam int SCL_W  = 11;   // hue * 6
   localparam int NUM_W  = 15;   // numerators up to 25500
   localparam int PROD_W = 22;   // v * numerator up to 2550000

   // Arithmetic constants
   localparam int PCT_MAX    = 100;
   localparam int CH_MAX     = 255;
   localparam int SECTOR_CNT = 6;
   localparam int FULL_SCALE = PCT_MAX * CH_MAX;   // 25500
   localparam int PCT_DIV    = PCT_MAX;            // divisor for V
   localparam int PCT2_DIV   = PCT_MAX * PCT_MAX;  // divisor for P, Q, T

   // Hue sectors, in circle order
   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

endpackage

`default_nettype wire

@@ sv/hsv_to_rgb_converter.sv @@
// HSV to RGB pixel converter. Takes one pixel (hue 0..255 around the circle,
// saturation and value in percent, codes above 100 read as 100) and returns
// 8-bit red, green and blue, each truncated toward zero. Five register stages:
// sector decode, numerators, value multiply, reciprocal multiply, correction
// and channel select. One pixel enters per clock while req_ready is high;
// each full stage holds while the one after it is stalled,
// so req_ready follows rsp_ready through the chain of stage enables.
`default_nettype none

module hsv_to_rgb_converter
   import hsv_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire logic [HUE_W-1:0] req_hue,
   input  wire logic [PCT_W-1:0] req_saturation,
   input  wire logic [PCT_W-1:0] req_brightness,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      logic [CH_W-1:0]  rsp_red,
   output      logic [CH_W-1:0]  rsp_green,
   output      logic [CH_W-1:0]  rsp_blue
);

   localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(PCT_MAX);
   localparam logic [CH_W-1:0]  CH_FULL  = CH_W'(CH_MAX);
   localparam logic [NUM_W-1:0] NUM_FULL = NUM_W'(FULL_SCALE);
   localparam logic [NUM_W-1:0] NUM_CH   = NUM_W'(CH_MAX);
   localparam logic [SCL_W-1:0] THR1 = SCL_W'(CH_MAX);
   localparam logic [SCL_W-1:0] THR2 = SCL_W'(2 * CH_MAX);
   localparam logic [SCL_W-1:0] THR3 = SCL_W'(3 * CH_MAX);
   localparam logic [SCL_W-1:0] THR4 = SCL_W'(4 * CH_MAX);
   localparam logic [SCL_W-1:0] THR5 = SCL_W'(5 * CH_MAX);
   localparam logic [SCL_W-1:0] THR6 = SCL_W'(SECTOR_CNT * CH_MAX);

   // Stage enables, from the output back
   logic en1, en2, en3, en4, en5;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;

   assign en5 = !rsp_valid_ff || rsp_ready;
   assign en4 = !s4_valid_ff || en5;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;

   assign req_ready = en1;
   assign rsp_valid = rsp_valid_ff;

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff  <= req_valid;
         if (en2) s2_valid_ff  <= s1_valid_ff;
         if (en3) s3_valid_ff  <= s2_valid_ff;
         if (en4) s4_valid_ff  <= s3_valid_ff;
         if (en5) rsp_valid_ff <= s4_valid_ff;
      end
   end

   // ---------------- Stage 1: clamp and sector decode ----------------
   logic [SCL_W-1:0] scaled;
   logic [SCL_W-1:0] rem_wide;
   sector_type       sector_in;
   logic [PCT_W-1:0] sat_in, val_in;

   logic [PCT_W-1:0] s1_sat_ff, s1_val_ff;
   logic [CH_W-1:0]  s1_rem_ff;
   sector_type       s1_sector_ff;

   assign sat_in = (req_saturation > PCT_FULL) ? PCT_FULL : req_saturation;
   assign val_in = (req_brightness > PCT_FULL) ? PCT_FULL : req_brightness;
   assign scaled = (SCL_W'(req_hue) << 2) + (SCL_W'(req_hue) << 1);

   // Top of the hue circle wraps to the first sector with zero remainder
   always_comb begin
      if (scaled >= THR6) begin
         sector_in = SEC_RED_YEL;
         rem_wide  = scaled - THR6;
      end else if (scaled >= THR5) begin
         sector_in = SEC_MAG_RED;
         rem_wide  = scaled - THR5;
      end else if (scaled >= THR4) begin
         sector_in = SEC_BLU_MAG;
         rem_wide  = scaled - THR4;
      end else if (scaled >= THR3) begin
         sector_in = SEC_CYN_BLU;
         rem_wide  = scaled - THR3;
      end else if (scaled >= THR2) begin
         sector_in = SEC_GRN_CYN;
         rem_wide  = scaled - THR2;
      end else if (scaled >= THR1) begin
         sector_in = SEC_YEL_GRN;
         rem_wide  = scaled - THR1;
      end else begin
         sector_in = SEC_RED_YEL;
         rem_wide  = scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_sat_ff    <= sat_in;
         s1_val_ff    <= val_in;
         s1_rem_ff    <= rem_wide[CH_W-1:0];
         s1_sector_ff <= sector_in;
      end
   end

   // ---------------- Stage 2: numerators of P, Q, T ----------------
   logic [NUM_W-1:0] rem_s, irem_s, np_in;
   logic [CH_W-1:0]  irem;

   logic [NUM_W-1:0] s2_np_ff, s2_nq_ff, s2_nt_ff;
   logic [PCT_W-1:0] s2_val_ff;
   sector_type       s2_sector_ff;

   assign irem   = CH_FULL - s1_rem_ff;
   assign rem_s  = NUM_W'(s1_rem_ff) * NUM_W'(s1_sat_ff);
   assign irem_s = NUM_W'(irem) * NUM_W'(s1_sat_ff);
   assign np_in  = NUM_W'(PCT_FULL - s1_sat_ff) * NUM_CH;

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_np_ff     <= np_in;
         s2_nq_ff     <= NUM_FULL - rem_s;
         s2_nt_ff     <= NUM_FULL - irem_s;
         s2_val_ff    <= s1_val_ff;
         s2_sector_ff <= s1_sector_ff;
      end
   end

   // ---------------- Stage 3: scale by value ----------------
   logic [PROD_W-1:0] s3_xv_ff, s3_xp_ff, s3_xq_ff, s3_xt_ff;
   sector_type        s3_sector_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_xv_ff     <= PROD_W'(s2_val_ff) * PROD_W'(NUM_CH);
         s3_xp_ff     <= PROD_W'(s2_val_ff) * PROD_W'(s2_np_ff);
         s3_xq_ff     <= PROD_W'(s2_val_ff) * PROD_W'(s2_nq_ff);
         s3_xt_ff     <= PROD_W'(s2_val_ff) * PROD_W'(s2_nt_ff);
         s3_sector_ff <= s2_sector_ff;
      end
   end

   // ---------------- Stage 4: constant dividers ----------------
   logic [CH_W-1:0] cv, cp, cq, ct;
   sector_type      s4_sector_ff;

   hsv_cdiv #(.DIVISOR(PCT_DIV), .XW(PROD_W), .QW(CH_W)) u_div_v (
      .clock(clock), .en(en4), .x(s3_xv_ff), .q(cv)
   );
   hsv_cdiv #(.DIVISOR(PCT2_DIV), .XW(PROD_W), .QW(CH_W)) u_div_p (
      .clock(clock), .en(en4), .x(s3_xp_ff), .q(cp)
   );
   hsv_cdiv #(.DIVISOR(PCT2_DIV), .XW(PROD_W), .QW(CH_W)) u_div_q (
      .clock(clock), .en(en4), .x(s3_xq_ff), .q(cq)
   );
   hsv_cdiv #(.DIVISOR(PCT2_DIV), .XW(PROD_W), .QW(CH_W)) u_div_t (
      .clock(clock), .en(en4), .x(s3_xt_ff), .q(ct)
   );

   always_ff @(posedge clock) begin
      if (en4) s4_sector_ff <= s3_sector_ff;
   end

   // ---------------- Stage 5: six-way channel select ----------------
   logic [CH_W-1:0] red_in, green_in, blue_in;
   logic [CH_W-1:0] red_ff, green_ff, blue_ff;

   always_comb begin
      case (s4_sector_ff)
         SEC_RED_YEL: begin red_in = cv; green_in = ct; blue_in = cp; end
         SEC_YEL_GRN: begin red_in = cq; green_in = cv; blue_in = cp; end
         SEC_GRN_CYN: begin red_in = cp; green_in = cv; blue_in = ct; end
         SEC_CYN_BLU: begin red_in = cp; green_in = cq; blue_in = cv; end
         SEC_BLU_MAG: begin red_in = ct; green_in = cp; blue_in = cv; end
         default:     begin red_in = cv; green_in = cp; blue_in = cq; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

`default_nettype wire

@@ sv/hsv_cdiv.sv @@
// Division of an unsigned value by a constant: reciprocal multiply, one register,
// then a single compare-and-add correction. Depends on hsv_pkg.
`default_nettype none

module hsv_cdiv
   import hsv_pkg::*;
#(
   parameter int DIVISOR = PCT2_DIV,
   parameter int XW      = PROD_W,
   parameter int QW      = CH_W
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [XW-1:0] x,
   output      logic [QW-1:0] q
);

   localparam int RECIP_SHIFT = 32;
   localparam longint unsigned RECIP_L = (64'd1 << RECIP_SHIFT) / DIVISOR;
   localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'(RECIP_L);
   localparam logic [XW-1:0] DIV_X = XW'(DIVISOR);

   logic [XW+RECIP_SHIFT-1:0] prod;
   logic [QW-1:0]             est_in;
   logic [QW-1:0]             est_ff;
   logic [XW-1:0]             x_ff;
   logic [XW-1:0]             base;
   logic [XW-1:0]             rem_w;

   // Estimate is exact or one low, since the reciprocal is rounded down
   assign prod   = {{RECIP_SHIFT{1'b0}}, x} * {{XW{1'b0}}, RECIP};
   assign est_in = prod[RECIP_SHIFT +: QW];

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x;
         est_ff <= est_in;
      end
   end

   // Remainder check bumps the estimate when it fell one short
   assign base  = XW'(est_ff) * DIV_X;
   assign rem_w = x_ff - base;
   assign q     = (rem_w >= DIV_X) ? est_ff + QW'(1) : est_ff;

endmodule

`default_nettype wire

@@ sv/hsv_checker.sv @@
// Port-level checks on the HSV to RGB converter, bound to the top level.
// Depends on hsv_pkg and hsv_to_rgb_converter_defines.svh.
`default_nettype none
`include "hsv_to_rgb_converter_defines.svh"

module hsv_checker
   import hsv_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic [PCT_W-1:0] req_saturation,
   input wire logic [PCT_W-1:0] req_brightness,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [CH_W-1:0]  rsp_red,
   input wire logic [CH_W-1:0]  rsp_green,
   input wire logic [CH_W-1:0]  rsp_blue
);

   logic                req_take;
   logic                rsp_stall;
   logic                rsp_gray;
   logic                rsp_black;
   logic [3*CH_W-1:0]   rsp_pixel;

   assign req_take  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_gray  = (rsp_red == rsp_green) && (rsp_green == rsp_blue);
   assign rsp_black = (rsp_red == '0) && (rsp_green == '0) && (rsp_blue == '0);
   assign rsp_pixel = {rsp_red, rsp_green, rsp_blue};

   // A gray item taken, then rsp_ready high through the rest of the sequence
   sequence gray_pass;
      (req_take && req_saturation == '0) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
         ##1 rsp_ready;
   endsequence

   // A dark item taken, then rsp_ready high through the rest of the sequence
   sequence dark_pass;
      (req_take && req_brightness == '0) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
         ##1 rsp_ready;
   endsequence

   // Stalled item holds until taken
   `HSV_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_pixel), "stalled item changed")

   // A free output side never blocks the input
   `HSV_ASSERT_NOW(a_no_backpressure, rsp_ready, req_ready, "input blocked while output is free")

   // Zero saturation comes out as gray when the output runs free
   `HSV_ASSERT_NEXT(a_gray, gray_pass, rsp_valid && rsp_gray, "zero saturation item not gray")

   // Zero value comes out as black when the output runs free
   `HSV_ASSERT_NEXT(a_black, dark_pass, rsp_valid && rsp_black, "zero value item not black")

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (.*);

`default_nettype wire
